>>> design/assert_macros.svh
// Assertion macros for the integral damping force controller.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IDFC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("idfc check failed: same-cycle implication");

`define IDFC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("idfc check failed: next-cycle implication");

`else

`define IDFC_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`define IDFC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> design/idfc_pkg.sv
// Shared types, register indexes and saturation helpers for the
// integral damping force controller. No dependencies.
package idfc_pkg;

	localparam int Q_W     = 32;
	localparam int SP_W    = 31;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W  = 2 * Q_W;
	localparam int FRAC_W  = 16;
	localparam int WIDE_W  = 50;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_SCALE   = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_I,
		ST_MUL_D,
		ST_FORCE,
		ST_MUL_F,
		ST_VEL
	} idfc_state_t;

	typedef enum logic [1:0] {
		MUL_IG_ERR,
		MUL_DG_VEL,
		MUL_F_FS
	} mul_sel_t;

	typedef struct packed {
		logic     ld_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     upd_int;
		logic     upd_force;
		logic     upd_vel;
	} idfc_cmd_t;

	function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
		ovf32 = !((&v[WIDE_W-1:Q_W-1]) || !(|v[WIDE_W-1:Q_W-1]));
	endfunction

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		if (ovf32(v)) begin
			sat32 = v[WIDE_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		end else begin
			sat32 = v[Q_W-1:0];
		end
	endfunction

	function automatic logic signed [WIDE_W-1:0] ext32(input logic signed [Q_W-1:0] v);
		ext32 = {{(WIDE_W-Q_W){v[Q_W-1]}}, v};
	endfunction

endpackage

>>> design/idfc_ctrl.sv
// Sequencer for the integral damping force controller.
// Depends on idfc_pkg; drives the datapath command word and both handshakes.
module idfc_ctrl import idfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      position_valid,
	output logic      position_stall,
	output logic      result_valid,
	input  logic      result_stall,
	output idfc_cmd_t cmd
);

	idfc_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.upd_vel) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.mul_sel    = MUL_IG_ERR;
		position_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				position_stall = 1'b0;
				if (position_valid) begin
					cmd.ld_err = 1'b1;
					state_d    = ST_MUL_I;
				end
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_IG_ERR;
				state_d     = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.upd_int = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DG_VEL;
				state_d     = ST_FORCE;
			end
			ST_FORCE: begin
				cmd.upd_force = 1'b1;
				state_d       = ST_MUL_F;
			end
			ST_MUL_F: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_F_FS;
				state_d     = ST_VEL;
			end
			ST_VEL: begin
				// wait until the output word is free
				if (!(out_valid_q && result_stall)) begin
					cmd.upd_vel = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

>>> design/idfc_dp.sv
// Datapath: config registers, shared 32x32 multiplier, saturating adders
// and controller state. Depends on idfc_pkg; steered by idfc_ctrl.
module idfc_dp import idfc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [Q_W-1:0]          cfg_data,
	input  logic signed [Q_W-1:0]   position,
	input  idfc_cmd_t               cmd,
	output logic signed [Q_W-1:0]   velocity_command,
	output logic                    saturated
);

	logic [SP_W-1:0]        setpoint_q;
	logic signed [Q_W-1:0]  integral_gain_q, damping_gain_q, force_scale_q;
	logic signed [Q_W-1:0]  force_integral_q, velocity_q, prev_increment_q;
	logic signed [Q_W-1:0]  err_q, force_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                   flag_q;
	logic signed [Q_W-1:0]  vcmd_q;
	logic                   sat_q;

	logic signed [Q_W-1:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [WIDE_W-1:0] prod_sh, err_w, int_sum, force_sum, vel_sum;
	logic signed [Q_W-1:0]    prod_sat;
	logic                     prod_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q      <= '0;
			integral_gain_q <= '0;
			damping_gain_q  <= '0;
			force_scale_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:      setpoint_q      <= cfg_data[SP_W-1:0];
				REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data;
				REG_DAMPING_GAIN:  damping_gain_q  <= cfg_data;
				REG_FORCE_SCALE:   force_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_IG_ERR: begin
				mul_a = integral_gain_q;
				mul_b = err_q;
			end
			MUL_DG_VEL: begin
				mul_a = damping_gain_q;
				mul_b = velocity_q;
			end
			MUL_F_FS: begin
				mul_a = force_q;
				mul_b = force_scale_q;
			end
			default: begin
				mul_a = force_q;
				mul_b = force_scale_q;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// floor shift by the fraction width
	assign prod_sh  = {{(WIDE_W-PROD_W+FRAC_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:FRAC_W]};
	assign prod_sat = sat32(prod_sh);
	assign prod_ovf = ovf32(prod_sh);

	assign err_w     = {{(WIDE_W-SP_W){1'b0}}, setpoint_q} - ext32(position);
	assign int_sum   = ext32(force_integral_q) + ext32(prod_sat);
	assign force_sum = ext32(force_integral_q) - ext32(prod_sat);
	assign vel_sum   = ext32(velocity_q) + ext32(prev_increment_q) + ext32(prod_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_integral_q <= '0;
			velocity_q       <= '0;
			prev_increment_q <= '0;
		end else begin
			if (cmd.upd_int) begin
				force_integral_q <= sat32(int_sum);
			end
			if (cmd.upd_vel) begin
				velocity_q       <= sat32(vel_sum);
				prev_increment_q <= prod_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.ld_err) begin
			err_q  <= sat32(err_w);
			flag_q <= ovf32(err_w);
		end else if (cmd.upd_int) begin
			flag_q <= flag_q | prod_ovf | ovf32(int_sum);
		end else if (cmd.upd_force) begin
			force_q <= sat32(force_sum);
			flag_q  <= flag_q | prod_ovf | ovf32(force_sum);
		end
		if (cmd.upd_vel) begin
			vcmd_q <= sat32(vel_sum);
			sat_q  <= flag_q | prod_ovf | ovf32(vel_sum);
		end
	end

	assign velocity_command = vcmd_q;
	assign saturated        = sat_q;

endmodule

>>> design/integral_damping_force_controller_core.sv
// Top level of the integral damping force controller.
// Depends on idfc_pkg, idfc_ctrl, idfc_dp and assert_macros.svh.
//
// One position word in gives one velocity command word out. The word is taken
// in idle; the sequencer then steps through ST_MUL_I, ST_MUL_D, ST_FORCE,
// ST_MUL_F and ST_VEL before the result is presented, and takes no new position
// until it is back in idle. One shared 32x32 multiplier serves the integral,
// damping and force-scale products in dependent order, each product registered
// before the saturating add that uses it. The output word sits in a register, so
// the next position is taken while a result waits; a result still unclaimed when
// the next one is ready holds the sequencer.
`include "assert_macros.svh"

module integral_damping_force_controller_core import idfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [Q_W-1:0]        cfg_data,
	input  logic                  position_valid,
	output logic                  position_stall,
	input  logic signed [Q_W-1:0] position,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic signed [Q_W-1:0] velocity_command,
	output logic                  saturated
);

	idfc_cmd_t cmd;

	idfc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.position_valid (position_valid),
		.position_stall (position_stall),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.cmd            (cmd)
	);

	idfc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.position         (position),
		.cmd              (cmd),
		.velocity_command (velocity_command),
		.saturated        (saturated)
	);

	`IDFC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, position_valid && !position_stall, position_stall)
	`IDFC_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.upd_vel, !(result_valid && result_stall))
	`IDFC_ASSERT_IMPL(a_result_from_update, clk, arst_n, $rose(result_valid), $past(cmd.upd_vel))

endmodule

>>> tb/sv/integral_damping_force_controller_core_tb.sv
`timescale 1ns / 100ps
// Testbench for integral_damping_force_controller_core: position words in, velocity commands
// out, checked word by word against a Q16.16 prediction of the control loop.
// Depends on idfc_pkg and the controller RTL.

module integral_damping_force_controller_core_tb;
	import idfc_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_PHASES   = 10;
	localparam int WORDS_PER_PHASE = 110;

	localparam logic signed [Q_W-1:0] Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [Q_W-1:0] ONE_Q  = 32'sh0001_0000;
	localparam logic signed [Q_W-1:0] HALF_Q = 32'sh0000_8000;

	typedef struct packed {
		logic signed [Q_W-1:0] velocity;
		logic                  saturated;
	} command_t;

	class velocity_command_tracker;
		logic [SP_W-1:0]       setpoint;
		logic signed [Q_W-1:0] integral_gain;
		logic signed [Q_W-1:0] damping_gain;
		logic signed [Q_W-1:0] force_scale;
		logic signed [Q_W-1:0] force_integral;
		logic signed [Q_W-1:0] velocity;
		logic signed [Q_W-1:0] prev_increment;
		logic                  clipped;
		command_t              expected_commands[$];
		int                    mismatch_count;

		function new();
			setpoint       = '0;
			integral_gain  = '0;
			damping_gain   = '0;
			force_scale    = '0;
			force_integral = '0;
			velocity       = '0;
			prev_increment = '0;
			mismatch_count = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
			case (idx)
				REG_SETPOINT:      setpoint      = data[SP_W-1:0];
				REG_INTEGRAL_GAIN: integral_gain = data;
				REG_DAMPING_GAIN:  damping_gain  = data;
				REG_FORCE_SCALE:   force_scale   = data;
				default: ;
			endcase
		endfunction

		function logic signed [Q_W-1:0] saturate(longint v);
			if (v > longint'(Q_MAX)) begin
				clipped = 1'b1;
				return Q_MAX;
			end
			if (v < longint'(Q_MIN)) begin
				clipped = 1'b1;
				return Q_MIN;
			end
			return v[Q_W-1:0];
		endfunction

		// exact product, floor shift, saturate
		function logic signed [Q_W-1:0] qmul(logic signed [Q_W-1:0] a, logic signed [Q_W-1:0] b);
			longint prod;
			prod = longint'(a) * longint'(b);
			return saturate(prod >>> FRAC_W);
		endfunction

		function void note_position(logic signed [Q_W-1:0] pos);
			logic signed [Q_W-1:0] err;
			logic signed [Q_W-1:0] int_term;
			logic signed [Q_W-1:0] damp_term;
			logic signed [Q_W-1:0] force_now;
			logic signed [Q_W-1:0] inc;
			command_t              cmd;
			clipped        = 1'b0;
			err            = saturate(longint'(setpoint) - longint'(pos));
			int_term       = qmul(integral_gain, err);
			force_integral = saturate(longint'(force_integral) + longint'(int_term));
			damp_term      = qmul(damping_gain, velocity);
			force_now      = saturate(longint'(force_integral) - longint'(damp_term));
			inc            = qmul(force_now, force_scale);
			velocity       = saturate(longint'(velocity) + longint'(prev_increment)
				+ longint'(inc));
			prev_increment = inc;
			cmd.velocity   = velocity;
			cmd.saturated  = clipped;
			expected_commands.push_back(cmd);
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %0s", $time, msg);
			mismatch_count++;
		endtask

		task check_command(logic signed [Q_W-1:0] vel, logic sat);
			command_t want;
			if (expected_commands.size() == 0) begin
				report_mismatch($sformatf("velocity_command %h with nothing pending", vel));
				return;
			end
			want = expected_commands.pop_front();
			if (vel !== want.velocity)
				report_mismatch($sformatf("velocity_command %h, want %h", vel, want.velocity));
			if (sat !== want.saturated)
				report_mismatch($sformatf("saturated %b, want %b", sat, want.saturated));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [Q_W-1:0]        cfg_data;
	logic                  position_valid;
	logic                  position_stall;
	logic signed [Q_W-1:0] position;
	logic                  result_valid;
	logic                  result_stall;
	logic signed [Q_W-1:0] velocity_command;
	logic                  saturated;

	velocity_command_tracker tracker = new();
	int cycle_count = 0;
	int stall_left  = 0;
	int stall_mode  = 0;

	integral_damping_force_controller_core i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (position_valid && !position_stall)
				tracker.note_position(position);
			if (result_valid && !result_stall)
				tracker.check_command(velocity_command, saturated);
		end
	end

	// receiver: free-running, light, heavy and long-run stall modes
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(3);
			stall_left = $urandom_range(10, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(3) == 0);
			2: result_stall <= ($urandom_range(3) != 0);
			default: result_stall <= ((stall_left % 24) < 15);
		endcase
	end

	function automatic int signed_span(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic signed [Q_W-1:0] pick_position();
		logic signed [Q_W-1:0] pos;
		case ($urandom_range(15))
			0: pos = Q_MAX;
			1: pos = Q_MIN;
			2, 3, 4: pos = $urandom();
			default: pos = Q_W'(longint'(tracker.setpoint) + longint'(signed_span(1 << 18)));
		endcase
		return pos;
	endfunction

	function automatic logic [Q_W-1:0] pick_gain(input int span);
		case ($urandom_range(11))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return $urandom();
			3: return '0;
			default: return signed_span(span);
		endcase
	endfunction

	function automatic logic [Q_W-1:0] pick_setpoint();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return $urandom();
			default: return $urandom_range(1 << 24) ^ ($urandom_range(1) << 31);
		endcase
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		tracker.write_register(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [Q_W-1:0] sp, input logic [Q_W-1:0] ig,
		input logic [Q_W-1:0] dg, input logic [Q_W-1:0] fs);
		// writes past the last register must be ignored
		if ($urandom_range(2) == 0)
			write_register(CFG_IDX_W'(REG_FORCE_SCALE + 1 + $urandom_range(3)), $urandom());
		write_register(REG_SETPOINT, sp);
		write_register(REG_INTEGRAL_GAIN, ig);
		write_register(REG_DAMPING_GAIN, dg);
		write_register(REG_FORCE_SCALE, fs);
	endtask

	// called at a rising edge; returns at the edge that takes the word
	task automatic send_word(input logic signed [Q_W-1:0] word);
		position_valid <= 1'b1;
		position       <= word;
		do @(posedge clk); while (!(position_valid && !position_stall));
	endtask

	task automatic drain();
		position_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_commands.size() != 0) @(posedge clk);
	endtask

	task automatic run_positions(input int count);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 40);
		for (int n = 0; n < count; n++) begin
			send_word(pick_position());
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					position_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		position_valid = 1'b0;
		position       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 1; k <= 4; k++)
			write_register(CFG_IDX_W'(REG_FORCE_SCALE + k), $urandom());

		// error clip at the position extremes, top bit of setpoint data dropped
		configure('1, '0, '0, '0);
		send_word(Q_MIN);
		send_word(Q_MAX);
		send_word('0);
		send_word('1);
		drain();

		// integral product, integrator, force, increment and velocity clips
		configure('0, Q_MAX, '0, ONE_Q);
		send_word(Q_MIN);
		send_word(Q_MIN);
		send_word(Q_MAX);
		send_word(Q_MAX);
		send_word(Q_MAX);
		drain();

		// damping and increment products at the negative extreme
		configure(pick_setpoint(), '0, Q_MIN, Q_MIN);
		repeat (3) send_word(pick_position());
		drain();

		// floor rounding of small negative products
		configure('0, 32'sd1, 32'sd3, HALF_Q);
		send_word(32'sd1);
		send_word(-32'sd1);
		send_word(32'sh0001_0001);
		send_word(32'shFFFF_0001);
		send_word(32'sd3);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			configure(pick_setpoint(), pick_gain(1 << 14), pick_gain(1 << 16),
				pick_gain(1 << 15));
			run_positions(WORDS_PER_PHASE);
			drain();
		end

		repeat (16) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.expected_commands.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
